FILE: src/i2d_pkg.sv
`timescale 1ns / 1ps

package i2d_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned MaxDigits  = 10;
  localparam int unsigned IdxWidth   = 4;

  // Reciprocal of ten at 2^35 scale: floor(x * Recip10 / 2^35) == x / 10 for all 32-bit x.
  localparam logic [ValueWidth-1:0] Recip10 = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 35;

  localparam logic [CharWidth-1:0] CharZero  = 8'd48;
  localparam logic [CharWidth-1:0] CharMinus = 8'd45;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } i2d_state_e;

  // Quotient and remainder of one division by ten.
  typedef struct packed {
    logic [ValueWidth-1:0] quo;
    logic [DigitWidth-1:0] rem;
  } div_res_t;

endpackage

FILE: src/i2d_in_if.sv
`timescale 1ns / 1ps

interface i2d_in_if;
  import i2d_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ValueWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

FILE: src/i2d_out_if.sv
`timescale 1ns / 1ps

interface i2d_out_if;
  import i2d_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] character;
  logic                 last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

FILE: src/i2d_div10.sv
`timescale 1ns / 1ps

// Divide-by-ten unit. The product is registered; quotient and remainder are
// formed from the registered product and the registered dividend.
module i2d_div10 import i2d_pkg::*; (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  logic [ValueWidth-1:0] x_i,
  output div_res_t              res_o
);

  logic [ValueWidth-1:0]   x_q;
  logic [2*ValueWidth-1:0] prod_q;
  logic [2*ValueWidth-1:0] prod_d;
  logic [ValueWidth-1:0]   quo;
  logic [ValueWidth-1:0]   quo_x10;
  logic [ValueWidth-1:0]   diff;

  assign prod_d = {{ValueWidth{1'b0}}, x_i} * {{ValueWidth{1'b0}}, Recip10};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q    <= x_i;
      prod_q <= prod_d;
    end
  end

  assign quo     = ValueWidth'(prod_q[2*ValueWidth-1:RecipShift]);
  assign quo_x10 = (quo << 3) + (quo << 1);
  assign diff    = x_q - quo_x10;

  assign res_o.quo = quo;
  assign res_o.rem = diff[DigitWidth-1:0];

endmodule

FILE: src/i2d_seq.sv
`timescale 1ns / 1ps

// Sequencer: drives the divide unit once per digit, keeps the digits, then
// plays them out most significant first through an output register.
module i2d_seq import i2d_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  neg_i,
  input  logic [ValueWidth-1:0] mag_i,
  output logic                  div_load_o,
  output logic [ValueWidth-1:0] div_x_o,
  input  div_res_t              div_res_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CharWidth-1:0]  out_char_o,
  output logic                  out_last_o
);

  i2d_state_e            state_q, state_d;
  logic [IdxWidth-1:0]   nd_q, nd_d;
  logic [IdxWidth-1:0]   rd_q, rd_d;
  logic                  sign_q, sign_d;
  logic                  ovalid_q, ovalid_d;
  logic [CharWidth-1:0]  ochar_q, ochar_d;
  logic                  olast_q, olast_d;
  logic [DigitWidth-1:0] dig_q [MaxDigits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      nd_q     <= '0;
      rd_q     <= '0;
      sign_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      nd_q     <= nd_d;
      rd_q     <= rd_d;
      sign_q   <= sign_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ochar_q <= ochar_d;
    olast_q <= olast_d;
    if (state_q == StConv) begin
      dig_q[nd_q] <= div_res_i.rem;
    end
  end

  always_comb begin
    state_d    = state_q;
    nd_d       = nd_q;
    rd_d       = rd_q;
    sign_d     = sign_q;
    ochar_d    = ochar_q;
    olast_d    = olast_q;
    ovalid_d   = ovalid_q && !out_ready_i;
    in_ready_o = 1'b0;
    div_load_o = 1'b0;
    div_x_o    = div_res_i.quo;

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          div_load_o = 1'b1;
          div_x_o    = mag_i;
          sign_d     = neg_i;
          nd_d       = '0;
          state_d    = StConv;
        end
      end
      StConv: begin
        // The remainder is written at nd_q this cycle; stop once nothing is left.
        if (div_res_i.quo == '0 || nd_q == IdxWidth'(MaxDigits - 1)) begin
          rd_d    = nd_q;
          state_d = StEmit;
        end else begin
          div_load_o = 1'b1;
          nd_d       = nd_q + 1'b1;
        end
      end
      StEmit: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          if (sign_q) begin
            ochar_d = CharMinus;
            olast_d = 1'b0;
            sign_d  = 1'b0;
          end else begin
            ochar_d = CharZero + {{(CharWidth-DigitWidth){1'b0}}, dig_q[rd_q]};
            olast_d = (rd_q == '0);
            if (rd_q == '0) begin
              state_d = StIdle;
            end else begin
              rd_d = rd_q - 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;

endmodule

FILE: src/int_to_decimal_ascii.sv
`timescale 1ns / 1ps

// Signed 32-bit integer to decimal ASCII text. Each input item is one
// two's complement integer; the block returns its decimal text as a run of
// output items, one ASCII character each, most significant first, with a
// leading '-' for negative values and last set on the final character.
// Zero gives the single character '0', and the most negative value is
// converted exactly because the magnitude is kept as an unsigned 32-bit word.
// A value is handled in order: it is accepted, its digits (1 to 10) are
// formed one at a time through the shared divide-by-ten unit (a
// reciprocal multiply with a registered product), and then any '-' and the
// stored digits are played out one character at a time, holding while the
// output is stalled. The input is not ready while a number is being
// converted or played out; the last character sits in the output register
// while the next value is accepted.
module int_to_decimal_ascii import i2d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  i2d_in_if.sink     in_i,
  i2d_out_if.source  out_o
);

  logic                  neg;
  logic [ValueWidth-1:0] mag;
  logic                  div_load;
  logic [ValueWidth-1:0] div_x;
  div_res_t              div_res;

  // The sign bit picks the two's complement negation; -2^31 maps to 2^31.
  assign neg = in_i.value[ValueWidth-1];
  assign mag = neg ? (~in_i.value + 1'b1) : in_i.value;

  i2d_div10 u_div10 (
    .clk_i  (clk_i),
    .load_i (div_load),
    .x_i    (div_x),
    .res_o  (div_res)
  );

  i2d_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .neg_i       (neg),
    .mag_i       (mag),
    .div_load_o  (div_load),
    .div_x_o     (div_x),
    .div_res_i   (div_res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.character),
    .out_last_o  (out_o.last)
  );

endmodule
